// File: sv/union_find_connectivity_assert.svh
// Assertion shorthands used by the checker file ufc_chk.sv.
`ifndef UNION_FIND_CONNECTIVITY_ASSERT_SVH
`define UNION_FIND_CONNECTIVITY_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define UFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ufc assertion failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define UFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ufc assertion failed");

`endif

// File: sv/ufc_pkg.sv
`timescale 1ns / 1ps

package ufc_pkg;

    localparam int NODE_W     = 10;
    localparam int NODE_SPACE = 2 ** NODE_W;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_VAL_A,
        S_VAL_B,
        S_FIND,
        S_START_B,
        S_LINK,
        S_DONE
    } t_state;

endpackage

// File: sv/ufc_if.sv
`timescale 1ns / 1ps

// Request channel.
interface ufc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ufc_pkg::NODE_W-1:0]  node_a;
    logic [ufc_pkg::NODE_W-1:0]  node_b;

    modport source (output valid, output req_type, output node_a, output node_b,
                    input ready);
    modport sink   (input valid, input req_type, input node_a, input node_b,
                    output ready);
endinterface

// Response channel.
interface ufc_rsp_if;
    logic valid;
    logic ready;
    logic same_component;
    logic range_error;

    modport source (output valid, output same_component, output range_error,
                    input ready);
    modport sink   (input valid, input same_component, input range_error,
                    output ready);
endinterface

// File: sv/union_find_connectivity.sv
`timescale 1ns / 1ps

// Disjoint-set (union-find) connectivity engine. Each request transaction on
// i_req either adds an edge between node_a and node_b (req_type 0) or asks
// whether the two nodes share a component (req_type 1); exactly one response
// transaction follows on o_rsp. Nodes at or beyond MAX_NODES give
// range_error = 1 and leave the state alone. An add between two distinct
// nodes links the larger root under the smaller one; every find points the
// queried node straight at its root. A node never added is connected only to
// itself. The parent table lives in one RAM with a registered read port, and
// a single sequencer walks parent links one read per cycle. After reset a
// clearing pass wipes all min(MAX_NODES, 1024) table entries; i_req.ready
// stays low until it ends. A request that is out of range or names one node
// twice goes straight to its response, a query that names an untouched node
// answers 0 without a walk, and an add skips the walk of each untouched
// node; every other node is walked along its parent links to its root, a
// path kept short by compression. The response becomes valid in the cycle in
// which i_req.ready returns. i_req.ready is high only while the sequencer is
// idle; a finished response waits in the output register without blocking
// the next request.
module union_find_connectivity #(
    parameter int MAX_NODES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ufc_req_if.sink   i_req,
    ufc_rsp_if.source o_rsp
);

    // Node fields are 10 bits wide, so no index beyond 1023 can reach the table.
    localparam int DEPTH = (MAX_NODES < ufc_pkg::NODE_SPACE) ? MAX_NODES
                                                              : ufc_pkg::NODE_SPACE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = AW + 1;
    localparam logic [31:0] LIMIT = 32'(MAX_NODES);

    typedef logic [AW-1:0] t_addr;
    // Table entry: touched flag plus parent index.
    typedef struct packed {
        logic  valid;
        t_addr parent;
    } t_entry;

    ufc_pkg::t_state r_state, n_state;

    // Control registers.
    t_addr  r_clr,       n_clr;
    logic   r_out_valid, n_out_valid;

    // Request and walk registers.
    logic   r_kind,  n_kind;
    t_addr  r_a,     n_a;
    t_addr  r_b,     n_b;
    logic   r_err,   n_err;
    logic   r_same,  n_same;
    logic   r_va,    n_va;      // node_a already touched
    logic   r_vb,    n_vb;      // node_b already touched
    logic   r_side,  n_side;    // 0: walking from a, 1: walking from b
    t_addr  r_cur,   n_cur;     // current node of the walk
    t_addr  r_ra,    n_ra;      // root of a
    t_addr  r_rb,    n_rb;      // root of b
    logic   r_out_same, n_out_same;
    logic   r_out_err,  n_out_err;

    // RAM port signals.
    logic   w_we;
    t_addr  w_waddr;
    t_entry w_wdata;
    t_addr  w_raddr;
    t_entry w_rd;

    logic   w_in_fire;
    logic   w_range_err;
    logic   w_same_node;
    logic   w_is_query;
    logic   w_at_root;
    logic   w_out_free;
    t_addr  w_lo;
    t_addr  w_hi;

    assign w_in_fire   = i_req.valid & i_req.ready;
    assign w_range_err = ({22'd0, i_req.node_a} >= LIMIT) ||
                         ({22'd0, i_req.node_b} >= LIMIT);
    assign w_same_node = (i_req.node_a == i_req.node_b);
    assign w_is_query  = (r_kind == ufc_pkg::REQ_QUERY);
    assign w_at_root   = (w_rd.parent == r_cur);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_lo        = (r_ra < r_rb) ? r_ra : r_rb;
    assign w_hi        = (r_ra < r_rb) ? r_rb : r_ra;

    ufc_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufc_pkg::S_CLEAR: begin
                if (r_clr == t_addr'(DEPTH - 1)) begin
                    n_state = ufc_pkg::S_IDLE;
                end
            end
            ufc_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (w_range_err || w_same_node) ? ufc_pkg::S_DONE
                                                           : ufc_pkg::S_VAL_A;
                end
            end
            ufc_pkg::S_VAL_A: begin
                n_state = ufc_pkg::S_VAL_B;
            end
            ufc_pkg::S_VAL_B: begin
                // A query with an untouched node answers 0 at once.
                priority if (w_is_query && !(r_va && w_rd.valid)) begin
                    n_state = ufc_pkg::S_DONE;
                end else if (!r_va) begin
                    n_state = ufc_pkg::S_START_B;
                end else begin
                    n_state = ufc_pkg::S_FIND;
                end
            end
            ufc_pkg::S_FIND: begin
                if (w_at_root) begin
                    n_state = r_side ? ufc_pkg::S_LINK : ufc_pkg::S_START_B;
                end
            end
            ufc_pkg::S_START_B: begin
                n_state = r_vb ? ufc_pkg::S_FIND : ufc_pkg::S_LINK;
            end
            ufc_pkg::S_LINK: begin
                n_state = ufc_pkg::S_DONE;
            end
            ufc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ufc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ufc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: table port control and request ready.
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_a;
        w_wdata     = '0;
        w_raddr     = r_a;
        i_req.ready = (r_state == ufc_pkg::S_IDLE);
        unique case (r_state)
            ufc_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            ufc_pkg::S_IDLE: begin
                w_raddr = t_addr'(i_req.node_a);
            end
            ufc_pkg::S_VAL_A: begin
                w_raddr = r_b;
            end
            ufc_pkg::S_VAL_B: begin
                // Untouched a in an add becomes its own root.
                if (!w_is_query && !r_va) begin
                    w_we    = 1'b1;
                    w_waddr = r_a;
                    w_wdata = '{valid: 1'b1, parent: r_a};
                end
                w_raddr = r_a;
            end
            ufc_pkg::S_FIND: begin
                if (w_at_root) begin
                    // Path compression on the queried node.
                    w_we    = 1'b1;
                    w_waddr = r_side ? r_b : r_a;
                    w_wdata = '{valid: 1'b1, parent: r_cur};
                end
                w_raddr = w_rd.parent;
            end
            ufc_pkg::S_START_B: begin
                if (!r_vb) begin
                    w_we    = 1'b1;
                    w_waddr = r_b;
                    w_wdata = '{valid: 1'b1, parent: r_b};
                end
                w_raddr = r_b;
            end
            ufc_pkg::S_LINK: begin
                if (!w_is_query && (r_ra != r_rb)) begin
                    w_we    = 1'b1;
                    w_waddr = w_hi;
                    w_wdata = '{valid: 1'b1, parent: w_lo};
                end
            end
            ufc_pkg::S_DONE: begin
                w_we = 1'b0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_clr       = r_clr;
        n_kind      = r_kind;
        n_a         = r_a;
        n_b         = r_b;
        n_err       = r_err;
        n_same      = r_same;
        n_va        = r_va;
        n_vb        = r_vb;
        n_side      = r_side;
        n_cur       = r_cur;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_out_same  = r_out_same;
        n_out_err   = r_out_err;
        n_out_valid = r_out_valid && !o_rsp.ready;
        unique case (r_state)
            ufc_pkg::S_CLEAR: begin
                n_clr = r_clr + t_addr'(1);
            end
            ufc_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_kind = i_req.req_type;
                    n_a    = t_addr'(i_req.node_a);
                    n_b    = t_addr'(i_req.node_b);
                    n_err  = w_range_err;
                    // A node is always connected to itself.
                    n_same = (i_req.req_type == ufc_pkg::REQ_QUERY) && w_same_node &&
                             !w_range_err;
                end
            end
            ufc_pkg::S_VAL_A: begin
                n_va = w_rd.valid;
            end
            ufc_pkg::S_VAL_B: begin
                n_vb   = w_rd.valid;
                n_side = 1'b0;
                n_cur  = r_a;
                n_ra   = r_a;
            end
            ufc_pkg::S_FIND: begin
                if (w_at_root) begin
                    if (r_side) begin
                        n_rb = r_cur;
                    end else begin
                        n_ra = r_cur;
                    end
                end else begin
                    n_cur = w_rd.parent;
                end
            end
            ufc_pkg::S_START_B: begin
                n_side = 1'b1;
                n_cur  = r_b;
                n_rb   = r_b;
            end
            ufc_pkg::S_LINK: begin
                n_same = w_is_query && (r_ra == r_rb);
            end
            ufc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_same  = r_same;
                    n_out_err   = r_err;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ufc_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_a        <= n_a;
        r_b        <= n_b;
        r_err      <= n_err;
        r_same     <= n_same;
        r_va       <= n_va;
        r_vb       <= n_vb;
        r_side     <= n_side;
        r_cur      <= n_cur;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_out_same <= n_out_same;
        r_out_err  <= n_out_err;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.same_component = r_out_same;
    assign o_rsp.range_error    = r_out_err;

endmodule

// File: sv/ufc_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
// Read during write to the same address returns the old contents.
module ufc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ufc_chk.sv
`timescale 1ns / 1ps

`include "union_find_connectivity_assert.svh"

// Port-level checks on the connectivity engine.
module ufc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_same,
    input logic i_err
);

    // Rejected requests never claim a connection.
    `UFC_ASSERT_IMP(a_err_not_same, i_out_valid && i_err, !i_same)
    // One request at a time: busy right after a transaction.
    `UFC_ASSERT_NXT(a_busy_after_req, i_in_valid && i_in_ready, !i_in_ready)
    `UFC_ASSERT_NXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid)
    `UFC_ASSERT_NXT(a_rsp_stable, i_out_valid && !i_out_ready,
                    $stable(i_same) && $stable(i_err))

endmodule

bind union_find_connectivity ufc_chk u_ufc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_same      (o_rsp.same_component),
    .i_err       (o_rsp.range_error)
);
